// ===== design/frd_pkg.sv =====
`default_nettype none

package frd_pkg;

   // Item opcodes carried on req_tuser
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_HINT   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Configuration register indexes
   localparam logic CSR_STABLE_THRESHOLD = 1'b0;
   localparam logic CSR_COUNT_CAP        = 1'b1;

   localparam logic [3:0] THRESHOLD_RESET = 4'd4;
   localparam logic [3:0] CAP_RESET       = 4'd8;

   localparam int TIME_W   = 64;
   localparam int HINT_W   = 8;
   localparam int REQ_W    = 2 * TIME_W + HINT_W;
   localparam int CNT_W    = 4;
   localparam int RATE_W   = 6;
   localparam int NUM_RATE = 4;
   localparam int WIN_W    = 19;

   // Gap windows, 100 ns units, inclusive; all fit below 2**WIN_W
   localparam logic [WIN_W-1:0] WIN24_LO = 19'd410000;
   localparam logic [WIN_W-1:0] WIN24_HI = 19'd450000;
   localparam logic [WIN_W-1:0] WIN25_LO = 19'd380000;
   localparam logic [WIN_W-1:0] WIN25_HI = 19'd409999;
   localparam logic [WIN_W-1:0] WIN30_LO = 19'd300000;
   localparam logic [WIN_W-1:0] WIN30_HI = 19'd360000;
   localparam logic [WIN_W-1:0] WIN60_LO = 19'd120000;
   localparam logic [WIN_W-1:0] WIN60_HI = 19'd220000;

   localparam logic [RATE_W-1:0] RATE_DEFAULT = 6'd60;

   typedef enum logic [1:0] {
      RATE_24 = 2'd0,
      RATE_25 = 2'd1,
      RATE_30 = 2'd2,
      RATE_60 = 2'd3
   } rate_code_type;

   typedef enum logic [2:0] {
      CMD_NOP   = 3'd0,
      CMD_BUMP  = 3'd1,
      CMD_DECAY = 3'd2,
      CMD_SEED  = 3'd3,
      CMD_CLEAR = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type  kind;
      rate_code_type rate;
   } cmd_type;

   function automatic logic [RATE_W-1:0] rate_value(input rate_code_type code);
      logic [RATE_W-1:0] v;
      case (code)
         RATE_24: v = 6'd24;
         RATE_25: v = 6'd25;
         RATE_30: v = 6'd30;
         RATE_60: v = 6'd60;
         default: v = RATE_DEFAULT;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== design/frame_rate_detector.sv =====
`default_nettype none

// Frame rate detector. Each item on the req_ channel is a timestamp sample,
// a rate hint or a state clear (opcode on req_tuser); every item returns one
// result on rsp_ carrying the detected rate (24, 25, 30 or 60 fps). The block
// takes one item per clock cycle while rsp_tready is high. The front end
// classifies the timestamp gap or hint in the accepting cycle, and the
// command is written into a two-entry queue at the accepting edge. Once it
// heads the queue and the output register is free or being read, the back
// end updates the four confidence counters and loads the output register.
// That counter update is what sets the one-item-per-cycle rate. While
// rsp_tready is low the output register holds its result and the queue
// takes two more items before req_tready drops. The two configuration
// registers may only be written while no item is in flight.
module frame_rate_detector (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [63:0] previous_time, [127:64] current_time, [135:128] hint_rate
   input  wire logic [135:0] req_tdata,
   // [1:0] opcode
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [5:0] source_rate, [7:6] zero
   output logic [7:0]       rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [3:0]  csr_data
);
   import frd_pkg::*;

   logic [CNT_W-1:0]  threshold_ff;
   logic [CNT_W-1:0]  cap_ff;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_not_empty;
   cmd_type           front_cmd;
   cmd_type           head_cmd;
   logic [RATE_W-1:0] rsp_rate;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         cap_ff       <= CAP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STABLE_THRESHOLD: threshold_ff <= csr_data;
            CSR_COUNT_CAP:        cap_ff       <= csr_data;
            default:              cap_ff       <= cap_ff;
         endcase
      end
   end

   frd_front u_front (
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .opcode        (req_tuser),
      .previous_time (req_tdata[TIME_W-1:0]),
      .current_time  (req_tdata[2*TIME_W-1:TIME_W]),
      .hint_rate     (req_tdata[REQ_W-1:2*TIME_W]),
      .queue_full    (q_full),
      .push          (push),
      .cmd           (front_cmd)
   );

   frd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   frd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .stable_threshold (threshold_ff),
      .count_cap        (cap_ff),
      .cmd_valid        (q_not_empty),
      .cmd              (head_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_rate         (rsp_rate)
   );

   assign rsp_tdata = {2'b00, rsp_rate};

endmodule

`default_nettype wire

// ===== design/frd_front.sv =====
`default_nettype none

module frd_front (
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  opcode,
   input  wire logic [frd_pkg::TIME_W-1:0]  previous_time,
   input  wire logic [frd_pkg::TIME_W-1:0]  current_time,
   input  wire logic [frd_pkg::HINT_W-1:0]  hint_rate,
   input  wire logic                        queue_full,
   output logic                             push,
   output frd_pkg::cmd_type                 cmd
);
   import frd_pkg::*;

   logic [TIME_W-1:0] gap;
   logic              usable;
   logic              gap_small;
   logic [WIN_W-1:0]  gap_low;
   logic              in24, in25, in30, in60;
   logic              hint_ok;
   rate_code_type     hint_code;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   assign usable    = !previous_time[TIME_W-1] && (|previous_time) &&
                      ($signed(current_time) > $signed(previous_time));
   assign gap       = current_time - previous_time;
   assign gap_small = ~|gap[TIME_W-1:WIN_W];
   assign gap_low   = gap[WIN_W-1:0];

   assign in24 = gap_small && gap_low >= WIN24_LO && gap_low <= WIN24_HI;
   assign in25 = gap_small && gap_low >= WIN25_LO && gap_low <= WIN25_HI;
   assign in30 = gap_small && gap_low >= WIN30_LO && gap_low <= WIN30_HI;
   assign in60 = gap_small && gap_low >= WIN60_LO && gap_low <= WIN60_HI;

   // Snap the hint; 25 and 26 go to 25
   always_comb begin
      hint_ok   = 1'b1;
      hint_code = RATE_60;
      if (hint_rate == 8'd23 || hint_rate == 8'd24) begin
         hint_code = RATE_24;
      end else if (hint_rate == 8'd25 || hint_rate == 8'd26) begin
         hint_code = RATE_25;
      end else if (hint_rate >= 8'd29 && hint_rate <= 8'd31) begin
         hint_code = RATE_30;
      end else if (hint_rate >= 8'd59 && hint_rate <= 8'd61) begin
         hint_code = RATE_60;
      end else begin
         hint_ok = 1'b0;
      end
   end

   always_comb begin
      cmd.kind = CMD_NOP;
      cmd.rate = RATE_60;
      case (opcode)
         OP_SAMPLE: begin
            if (usable) begin
               if (in24) begin
                  cmd.kind = CMD_BUMP;
                  cmd.rate = RATE_24;
               end else if (in25) begin
                  cmd.kind = CMD_BUMP;
                  cmd.rate = RATE_25;
               end else if (in30) begin
                  cmd.kind = CMD_BUMP;
                  cmd.rate = RATE_30;
               end else if (in60) begin
                  cmd.kind = CMD_BUMP;
                  cmd.rate = RATE_60;
               end else begin
                  cmd.kind = CMD_DECAY;
               end
            end
         end
         OP_HINT: begin
            if (hint_ok) begin
               cmd.kind = CMD_SEED;
               cmd.rate = hint_code;
            end
         end
         OP_CLEAR: cmd.kind = CMD_CLEAR;
         default:  cmd.kind = CMD_NOP;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/frd_queue.sv =====
`default_nettype none

module frd_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  frd_pkg::cmd_type push_cmd,
   input  wire logic        pop,
   output logic             full,
   output logic             not_empty,
   output frd_pkg::cmd_type head_cmd
);
   import frd_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== design/frd_back.sv =====
`default_nettype none

module frd_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [frd_pkg::CNT_W-1:0]    stable_threshold,
   input  wire logic [frd_pkg::CNT_W-1:0]    count_cap,
   input  wire logic                         cmd_valid,
   input  frd_pkg::cmd_type                  cmd,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [frd_pkg::RATE_W-1:0]        rsp_rate
);
   import frd_pkg::*;

   logic [CNT_W-1:0]  cnt_ff [NUM_RATE];
   logic [CNT_W-1:0]  cnt_in [NUM_RATE];
   logic [CNT_W-1:0]  bumped [NUM_RATE];
   logic [CNT_W-1:0]  decayed [NUM_RATE];
   logic [CNT_W:0]    inc [NUM_RATE];
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0] rsp_data_ff;

   assign pop       = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_rate  = rsp_data_ff;

   always_comb begin
      for (int i = 0; i < NUM_RATE; i++) begin
         inc[i]     = {1'b0, cnt_ff[i]} + 5'd1;
         bumped[i]  = (inc[i] > {1'b0, count_cap}) ? count_cap : inc[i][CNT_W-1:0];
         decayed[i] = (cnt_ff[i] != '0) ? cnt_ff[i] - 4'd1 : '0;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_RATE; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      rate_in = rate_ff;
      case (cmd.kind)
         CMD_BUMP, CMD_DECAY: begin
            for (int i = 0; i < NUM_RATE; i++) begin
               cnt_in[i] = (cmd.kind == CMD_BUMP && cmd.rate == rate_code_type'(i)) ?
                           bumped[i] : decayed[i];
            end
            // First qualifying counter in priority order wins
            if (cnt_in[RATE_24] >= stable_threshold) begin
               rate_in = rate_value(RATE_24);
            end else if (cnt_in[RATE_25] >= stable_threshold) begin
               rate_in = rate_value(RATE_25);
            end else if (cnt_in[RATE_30] >= stable_threshold) begin
               rate_in = rate_value(RATE_30);
            end else if (cnt_in[RATE_60] >= stable_threshold) begin
               rate_in = rate_value(RATE_60);
            end
         end
         CMD_SEED: begin
            for (int i = 0; i < NUM_RATE; i++) begin
               cnt_in[i] = (cmd.rate == rate_code_type'(i)) ? stable_threshold : '0;
            end
            rate_in = rate_value(cmd.rate);
         end
         CMD_CLEAR: begin
            for (int i = 0; i < NUM_RATE; i++) begin
               cnt_in[i] = '0;
            end
            rate_in = RATE_DEFAULT;
         end
         default: rate_in = rate_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_RATE; i++) begin
            cnt_ff[i] <= '0;
         end
         rate_ff      <= RATE_DEFAULT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            for (int i = 0; i < NUM_RATE; i++) begin
               cnt_ff[i] <= cnt_in[i];
            end
            rate_ff <= rate_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rate_in;
      end
   end

   a_rsp_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff == 6'd24 || rsp_data_ff == 6'd25 ||
                        rsp_data_ff == 6'd30 || rsp_data_ff == 6'd60))
      else $error("result rate is not a nominal rate");

   a_clear_default: assert property (@(posedge clock) disable iff (reset)
      (pop && cmd.kind == CMD_CLEAR) |=>
         (rate_ff == RATE_DEFAULT && rsp_data_ff == RATE_DEFAULT &&
          cnt_ff[RATE_24] == '0 && cnt_ff[RATE_60] == '0))
      else $error("clear item did not restore default state");

   a_seed_rate: assert property (@(posedge clock) disable iff (reset)
      (pop && cmd.kind == CMD_SEED) |=> rsp_data_ff == rate_value($past(cmd.rate)))
      else $error("hint item did not set its rate");

endmodule

`default_nettype wire
